[rtl/depth_edge_pixel_detect_defines.svh]
// assertion macros shared by the depth edge detector checker
`ifndef DEPTH_EDGE_PIXEL_DETECT_DEFINES_SVH
`define DEPTH_EDGE_PIXEL_DETECT_DEFINES_SVH

// implication into the next cycle, off while in reset
`define DEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication in the same cycle, off while in reset
`define DEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, checked through reset as well
`define DEP_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dep_pkg.sv]
// shared types and constants for the depth edge pixel detector
package dep_pkg;

  // field widths
  localparam int DEPTH_W     = 16;
  localparam int CFG_SIZE_W  = 11;
  localparam int COORD_W     = 10;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_TDATA_W = 24;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int DEPTH_BITS_DEF = 16;

  // frame size limits
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  // register reset values
  localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST    = 11'd640;
  localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RST   = 11'd480;
  localparam logic [DEPTH_W-1:0]    NEAR_THRESHOLD_RST = 16'd1;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_NEAR_THRESHOLD = 2'd2
  } cfg_idx_t;

  // position of a word as seen by the window stage
  typedef struct packed {
    logic               interior;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_t;

endpackage

[rtl/dep_ram.sv]
// generic single write port, single read port ram with registered read
module dep_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/dep_pos.sv]
// column and row counters with frame size clamping
module dep_pos #(
  parameter int MAX_WIDTH = dep_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [dep_pkg::CFG_SIZE_W-1:0]  frame_width,
  input  logic [dep_pkg::CFG_SIZE_W-1:0]  frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0]    addr,
  output dep_pkg::pos_t                   pos
);

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int MWID_W = $clog2(MAX_WIDTH + 1);
  localparam int SZ_W   = (MWID_W > dep_pkg::CFG_SIZE_W) ? MWID_W : dep_pkg::CFG_SIZE_W;
  localparam int HW     = dep_pkg::CFG_SIZE_W;

  logic [CNT_W-1:0]            col_r, col_nxt;
  logic [dep_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [SZ_W-1:0]             width_in, width_eff, col_ext, col_inc, col_dec;
  logic [HW-1:0]               height_eff, row_ext, row_inc, row_dec;

  // effective frame size
  always_comb begin
    width_in = SZ_W'(frame_width);
    if (width_in < SZ_W'(dep_pkg::MIN_SIZE)) begin
      width_eff = SZ_W'(dep_pkg::MIN_SIZE);
    end else if (width_in > SZ_W'(MAX_WIDTH)) begin
      width_eff = SZ_W'(MAX_WIDTH);
    end else begin
      width_eff = width_in;
    end
    if (frame_height < HW'(dep_pkg::MIN_SIZE)) begin
      height_eff = HW'(dep_pkg::MIN_SIZE);
    end else if (frame_height > HW'(dep_pkg::MAX_HEIGHT)) begin
      height_eff = HW'(dep_pkg::MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  // raster position arithmetic
  always_comb begin
    col_ext = SZ_W'(col_r);
    col_inc = col_ext + SZ_W'(1);
    col_dec = col_ext - SZ_W'(1);
    row_ext = HW'(row_r);
    row_inc = row_ext + HW'(1);
    row_dec = row_ext - HW'(1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      if (row_inc >= height_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[dep_pkg::COORD_W-1:0];
      end
    end else begin
      col_nxt = col_inc[CNT_W-1:0];
    end
  end

  // counters move once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // centre of the window sits one up and one left of the current pixel
  assign addr         = col_r;
  assign pos.interior = (col_ext >= SZ_W'(2)) && (row_ext >= HW'(2)) &&
                        (col_ext < width_eff) && (row_ext < height_eff);
  assign pos.col      = col_dec[dep_pkg::COORD_W-1:0];
  assign pos.row      = row_dec[dep_pkg::COORD_W-1:0];

endmodule

[rtl/dep_win.sv]
// 3x3 window columns and neighbour threshold test
module dep_win #(
  parameter int PIX_W = dep_pkg::DEPTH_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         interior,
  input  logic [PIX_W-1:0]             top,
  input  logic [PIX_W-1:0]             mid,
  input  logic [PIX_W-1:0]             bot,
  input  logic [dep_pkg::DEPTH_W-1:0]  near_threshold,
  output logic                         edge_hit
);

  // column c-2 in win_r[0..2], column c-1 in win_r[3..5], rows top to bottom
  logic [PIX_W-1:0]            win_r [6];
  logic [PIX_W-1:0]            nb [8];
  logic [dep_pkg::DEPTH_W-1:0] nb_ext [8];
  logic [dep_pkg::DEPTH_W-1:0] centre_ext;
  logic [7:0]                  below;

  // eight neighbours around the centre
  always_comb begin
    nb[0] = win_r[0];
    nb[1] = win_r[1];
    nb[2] = win_r[2];
    nb[3] = win_r[3];
    nb[4] = win_r[5];
    nb[5] = top;
    nb[6] = mid;
    nb[7] = bot;
    for (int k = 0; k < 8; k++) begin
      nb_ext[k] = dep_pkg::DEPTH_W'(nb[k]);
      below[k]  = nb_ext[k] < near_threshold;
    end
    centre_ext = dep_pkg::DEPTH_W'(win_r[4]);
  end

  assign edge_hit = interior && (centre_ext != '0) && (|below);

  // shift the window one column per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

endmodule

[rtl/depth_edge_pixel_detect.sv]
// top level of the streaming depth edge pixel detector
//
// Depth samples enter on the in_ stream one word per pixel in raster order.
// For every interior pixel whose depth is nonzero and that has at least one
// of its eight neighbours below near_threshold, one word with its column and
// row leaves on the out_ stream; other pixels give no word. The test for a
// centre pixel runs when the pixel below and to its right arrives.
// The cfg_ port writes frame_width, frame_height and near_threshold by index
// and is always ready; write it only while no pixel is in flight.
// Throughput is one pixel per cycle unless the receiver stalls: the two line
// buffers are rams with one write and one registered read port, read at
// accept and written as the word leaves the input register.
// Reset clears the counters, the window and the pipeline valid flags; the
// line buffers are not cleared, so the first two rows of the first frame
// give results only once both lines have been written.
// When the receiver stalls the result word holds, one more pixel is taken
// into the window stage, and then in_tready drops until the result leaves.
module depth_edge_pixel_detect #(
  parameter int MAX_WIDTH  = dep_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = dep_pkg::DEPTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // depth sample stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dep_pkg::DEPTH_W-1:0]       in_tdata,   // [15:0] depth_sample
  // edge pixel stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dep_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] edge_column, [19:10] edge_row
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dep_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int PIX_W = (DEPTH_BITS < dep_pkg::DEPTH_W) ? DEPTH_BITS : dep_pkg::DEPTH_W;

  logic [dep_pkg::CFG_SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [dep_pkg::DEPTH_W-1:0]    near_threshold_r;

  logic                in_fire, s1_fire;
  logic [CNT_W-1:0]    rd_addr;
  dep_pkg::pos_t       pos;

  logic                s1_valid_r;
  logic [PIX_W-1:0]    s1_bot_r;
  logic [CNT_W-1:0]    s1_addr_r;
  dep_pkg::pos_t       s1_pos_r;
  logic [PIX_W-1:0]    top_rd, mid_rd;
  logic                edge_hit;

  logic                              out_valid_r;
  logic [dep_pkg::OUT_TDATA_W-1:0]   out_data_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= dep_pkg::FRAME_WIDTH_RST;
      frame_height_r   <= dep_pkg::FRAME_HEIGHT_RST;
      near_threshold_r <= dep_pkg::NEAR_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (dep_pkg::cfg_idx_t'(cfg_index))
        dep_pkg::CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data[dep_pkg::CFG_SIZE_W-1:0];
        dep_pkg::CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_data[dep_pkg::CFG_SIZE_W-1:0];
        dep_pkg::CFG_NEAR_THRESHOLD: near_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: the window stage drains whenever the result register is free
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // raster counters
  dep_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (in_fire),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .addr         (rd_addr),
    .pos          (pos)
  );

  // line buffers: upper holds row r-2, middle holds row r-1
  dep_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr_r),
    .wr_data (mid_rd),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (top_rd)
  );

  dep_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr_r),
    .wr_data (s1_bot_r),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (mid_rd)
  );

  // input register, lined up with the line buffer read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bot_r  <= in_tdata[PIX_W-1:0];
      s1_addr_r <= rd_addr;
      s1_pos_r  <= pos;
    end
  end

  // window and threshold test
  dep_win #(
    .PIX_W (PIX_W)
  ) u_win (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (s1_fire),
    .interior       (s1_pos_r.interior),
    .top            (top_rd),
    .mid            (mid_rd),
    .bot            (s1_bot_r),
    .near_threshold (near_threshold_r),
    .edge_hit       (edge_hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= edge_hit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && edge_hit) begin
      out_data_r <= dep_pkg::OUT_TDATA_W'({s1_pos_r.row, s1_pos_r.col});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/dep_checker.sv]
// port level checker for the depth edge detector, bound to the top level
`include "depth_edge_pixel_detect_defines.svh"

module dep_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [dep_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // a stalled result word stays up and unchanged
  `DEP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `DEP_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")

  // the top border row is never reported and the padding stays zero
  `DEP_ASSERT_NOW(a_out_row, out_tvalid, (out_tdata[19:10] != '0) && (out_tdata[23:20] == '0), "bad row")

  // with no result waiting the input side is always ready
  `DEP_ASSERT_NOW(a_in_ready, !out_tvalid, in_tready, "input stalled with no result waiting")

  // no result word right after reset
  `DEP_ASSERT_RST(a_out_rst, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind depth_edge_pixel_detect dep_checker u_dep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/tb.sv]
// self-checking testbench for the streaming depth edge pixel detector
module tb;

  localparam int unsigned MAX_W       = dep_pkg::MAX_WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 40000;
  localparam int          DRAIN       = 8;

  typedef struct {
    logic [dep_pkg::COORD_W-1:0] col;
    logic [dep_pkg::COORD_W-1:0] row;
  } edge_pos_t;

  // clock, reset and dut ports
  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [dep_pkg::DEPTH_W-1:0]     in_tdata   = '0;    // [15:0] depth_sample
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dep_pkg::OUT_TDATA_W-1:0] out_tdata;   // [9:0] edge_column, [19:10] edge_row
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [dep_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [dep_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  // stimulus side
  logic [dep_pkg::DEPTH_W-1:0] depth_word_q [$];
  logic                        steady = 1'b0;
  int unsigned                 gen_w = 32'(dep_pkg::FRAME_WIDTH_RST);
  int unsigned                 gen_h = 32'(dep_pkg::FRAME_HEIGHT_RST);
  int unsigned                 gen_col = 0;
  int unsigned                 gen_row = 0;
  logic [dep_pkg::DEPTH_W-1:0] gen_thr = dep_pkg::NEAR_THRESHOLD_RST;
  int unsigned                 words_queued = 0;
  int unsigned                 settings_used = 0;

  // edge predictor state
  bit   [dep_pkg::DEPTH_W-1:0]    upper_mem  [MAX_W];
  bit   [dep_pkg::DEPTH_W-1:0]    middle_mem [MAX_W];
  bit   [dep_pkg::DEPTH_W-1:0]    win_col    [6];
  int unsigned                    col_pos = 0;
  int unsigned                    row_pos = 0;
  logic [dep_pkg::CFG_SIZE_W-1:0] cur_width  = dep_pkg::FRAME_WIDTH_RST;
  logic [dep_pkg::CFG_SIZE_W-1:0] cur_height = dep_pkg::FRAME_HEIGHT_RST;
  logic [dep_pkg::DEPTH_W-1:0]    cur_thresh = dep_pkg::NEAR_THRESHOLD_RST;

  // expected edge words and bookkeeping
  edge_pos_t   edge_pos_q [$];
  edge_pos_t   oldest;
  int unsigned words_accepted = 0;
  int unsigned edges_checked = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  depth_edge_pixel_detect dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // out-of-range sizes fall back to the nearest legal size
  function automatic int unsigned clamp_size(input logic [dep_pkg::CFG_SIZE_W-1:0] v,
                                             input int unsigned hi);
    if (v < dep_pkg::MIN_SIZE) return 32'(dep_pkg::MIN_SIZE);
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // one pixel into the window; queues an edge word for the centre if it qualifies
  function automatic void predict_edge_pixel(input logic [dep_pkg::DEPTH_W-1:0] sample);
    int unsigned               w, h, c, r, idx;
    bit [dep_pkg::DEPTH_W-1:0] top, mid;
    logic                      hit;
    edge_pos_t                 pos;
    w   = clamp_size(cur_width, MAX_W);
    h   = clamp_size(cur_height, 32'(dep_pkg::MAX_HEIGHT));
    c   = col_pos;
    r   = row_pos;
    idx = (c < MAX_W) ? c : MAX_W - 1;
    top = upper_mem[idx];
    mid = middle_mem[idx];
    hit = 1'b0;
    // centre is win_col[4]; the other eight are its neighbours
    if (c >= 2 && r >= 2 && c < w && r < h && win_col[4] != 0) begin
      hit = (win_col[0] < cur_thresh) || (win_col[1] < cur_thresh) ||
            (win_col[2] < cur_thresh) || (win_col[3] < cur_thresh) ||
            (win_col[5] < cur_thresh) || (top < cur_thresh) ||
            (mid < cur_thresh) || (sample < cur_thresh);
    end
    if (hit) begin
      pos.col = dep_pkg::COORD_W'(c - 1);
      pos.row = dep_pkg::COORD_W'(r - 1);
      edge_pos_q = {edge_pos_q, pos};
    end
    // shift the window and update the line buffers
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top;
    win_col[4] = mid;
    win_col[5] = sample;
    upper_mem[idx]  = mid;
    middle_mem[idx] = sample;
    // raster position with wrap at the frame size
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // depth values biased toward zero, the threshold and full scale
  function automatic logic [dep_pkg::DEPTH_W-1:0] pick_depth();
    int near_val;
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3: begin
        near_val = int'(gen_thr) + int'($urandom_range(0, 4)) - 2;
        if (near_val < 0) near_val = 0;
        if (near_val > 65535) near_val = 65535;
        return dep_pkg::DEPTH_W'(near_val);
      end
      4: return '1;
      default: return dep_pkg::DEPTH_W'($urandom);
    endcase
  endfunction

  // queue one depth word and track where it lands in the frame
  task automatic queue_depth(input logic [dep_pkg::DEPTH_W-1:0] value);
    depth_word_q = {depth_word_q, value};
    words_queued++;
    if (gen_col + 1 >= gen_w) begin
      gen_col = 0;
      gen_row = (gen_row + 1 >= gen_h) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endtask

  // whole frames of random content, or the rest of the current one
  task automatic send_frames(input int unsigned count);
    repeat (count) begin
      do queue_depth(pick_depth()); while (gen_col != 0 || gen_row != 0);
    end
  endtask

  // 3x3 frame: first and last corners, centre and the ring around it
  task automatic send_window(input logic [dep_pkg::DEPTH_W-1:0] first,
                             input logic [dep_pkg::DEPTH_W-1:0] ring,
                             input logic [dep_pkg::DEPTH_W-1:0] centre,
                             input logic [dep_pkg::DEPTH_W-1:0] last);
    for (int i = 0; i < 9; i++)
      queue_depth(i == 0 ? first : i == 4 ? centre : i == 8 ? last : ring);
  endtask

  // wait until every word is taken and every edge word has left, then drain
  task automatic wait_idle();
    do @(posedge clk); while (words_accepted != words_queued || edge_pos_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input dep_pkg::cfg_idx_t idx,
                           input logic [dep_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dep_pkg::CFG_FRAME_WIDTH:
        gen_w = clamp_size(value[dep_pkg::CFG_SIZE_W-1:0], MAX_W);
      dep_pkg::CFG_FRAME_HEIGHT:
        gen_h = clamp_size(value[dep_pkg::CFG_SIZE_W-1:0], 32'(dep_pkg::MAX_HEIGHT));
      dep_pkg::CFG_NEAR_THRESHOLD:
        gen_thr = value;
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [dep_pkg::CFG_SIZE_W-1:0] w,
                           input logic [dep_pkg::CFG_SIZE_W-1:0] h,
                           input logic [dep_pkg::DEPTH_W-1:0] thr);
    wait_idle();
    write_reg(dep_pkg::CFG_FRAME_WIDTH, dep_pkg::CFG_DATA_W'(w));
    write_reg(dep_pkg::CFG_FRAME_HEIGHT, dep_pkg::CFG_DATA_W'(h));
    write_reg(dep_pkg::CFG_NEAR_THRESHOLD, thr);
    settings_used++;
  endtask

  // depth word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (depth_word_q.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= depth_word_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // edge word receiver stalls
  always @(posedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 27);
  end

  // monitor: register writes, edge word checks, depth word predictions
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dep_pkg::CFG_FRAME_WIDTH:    cur_width  = cfg_data[dep_pkg::CFG_SIZE_W-1:0];
          dep_pkg::CFG_FRAME_HEIGHT:   cur_height = cfg_data[dep_pkg::CFG_SIZE_W-1:0];
          dep_pkg::CFG_NEAR_THRESHOLD: cur_thresh = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (edge_pos_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected edge word, expected none, actual col %0d row %0d",
                   $time, out_tdata[9:0], out_tdata[19:10]);
        end else begin
          oldest = edge_pos_q.pop_front();
          edges_checked++;
          if (out_tdata[9:0] !== oldest.col) begin
            errors++;
            $display("%0t: edge_column mismatch, expected %0d, actual %0d",
                     $time, oldest.col, out_tdata[9:0]);
          end
          if (out_tdata[19:10] !== oldest.row) begin
            errors++;
            $display("%0t: edge_row mismatch, expected %0d, actual %0d",
                     $time, oldest.row, out_tdata[19:10]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_edge_pixel(in_tdata);
        words_accepted++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d edge words still expected",
               cycles, edge_pos_q.size());
      $display("depth_edge_pixel_detect test failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned                    mark;
    int unsigned                    random_words;
    logic [dep_pkg::CFG_SIZE_W-1:0] w, h;
    logic [dep_pkg::DEPTH_W-1:0]    thr;
    random_words = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame: full-scale ring with one empty corner, all-zero, threshold edge
    set_frame(11'd3, 11'd3, 16'd100);
    send_window(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_window(16'd0, 16'd0, 16'd0, 16'd0);
    send_window(16'd100, 16'd100, 16'd1, 16'd99);

    // random frames, mostly small sizes
    while (random_words < 500) begin
      case ($urandom_range(0, 7))
        0:       w = dep_pkg::CFG_SIZE_W'($urandom_range(0, 2));
        1:       w = dep_pkg::CFG_SIZE_W'($urandom_range(13, 40));
        default: w = dep_pkg::CFG_SIZE_W'($urandom_range(3, 12));
      endcase
      h = ($urandom_range(0, 5) == 0) ? dep_pkg::CFG_SIZE_W'($urandom_range(0, 2)) :
                                        dep_pkg::CFG_SIZE_W'($urandom_range(3, 8));
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = 16'd1;
        2:       thr = '1;
        3:       thr = dep_pkg::DEPTH_W'($urandom);
        default: thr = dep_pkg::DEPTH_W'($urandom_range(2, 300));
      endcase
      set_frame(w, h, thr);
      steady = ($urandom_range(0, 5) == 0);
      mark = words_queued;
      send_frames($urandom_range(1, 2));
      random_words += words_queued - mark;
    end

    // width past the limit and height below it, first row only, no idling
    set_frame(11'd2047, 11'd0, dep_pkg::DEPTH_W'($urandom_range(1, 300)));
    steady = 1'b1;
    for (int i = 0; i < 40; i++) queue_depth(pick_depth());

    // height past the limit and width below it, rows well past the usual sizes
    set_frame(11'd1, 11'd2047, dep_pkg::DEPTH_W'($urandom_range(1, 300)));
    for (int i = 0; i < 60; i++) queue_depth(pick_depth());

    // size shrunk mid-frame: column and row counters past the new size wrap
    set_frame(11'd10, 11'd10, 16'd40);
    steady = 1'b0;
    send_frames(1);
    for (int i = 0; i < 47; i++) queue_depth(pick_depth());
    wait_idle();
    write_reg(dep_pkg::CFG_FRAME_WIDTH, 16'd5);
    write_reg(dep_pkg::CFG_FRAME_HEIGHT, 16'd4);
    write_reg(dep_pkg::CFG_NEAR_THRESHOLD, 16'd200);
    settings_used++;
    send_frames(1);
    send_frames(2);

    wait_idle();
    $display("%0d depth words over %0d frame settings, %0d edge words checked",
             words_accepted, settings_used, edges_checked);
    $display("frame sizes below and past the legal range, mismatches: %0d", errors);
    if (errors == 0) begin
      $display("depth_edge_pixel_detect test passed");
    end else begin
      $display("depth_edge_pixel_detect test failed");
    end
    $finish;
  end

endmodule
